// File: hdl/vector_normalize_assert.svh
// assertion macros for the vector normalisation block
`ifndef VECTOR_NORMALIZE_ASSERT_SVH
`define VECTOR_NORMALIZE_ASSERT_SVH

// checked outside reset
`define VN_ASSERT_RUN(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vector_normalize: check failed");

// checked on every edge, reset included
`define VN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("vector_normalize: check failed");

`endif

// File: hdl/vn_pkg.sv
// shared constants and width helpers for the vector normalisation block
package vn_pkg;
    localparam int NUM_LANES          = 4;
    localparam int DEF_COMPONENT_BITS = 16;
    localparam int DEF_LANES          = 4;
    localparam int UNIT_SHIFT         = 14;
    localparam int UNIT_W             = 16;
    localparam int LEN_OUT_W          = 17;
    localparam int MIN_LEN_W          = 16;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 16'd1;
    localparam int OUT_DATA_W = ((NUM_LANES * UNIT_W + LEN_OUT_W + 7) / 8) * 8;

    typedef logic [UNIT_W-1:0] t_unit;

    // width of the square root result for a given component width
    function automatic int len_w(input int cb);
        int sum_w;
        int clamp_w;
        sum_w   = 2 * cb + 2;
        clamp_w = (sum_w > 64) ? 64 : sum_w;
        return (clamp_w + 1) / 2;
    endfunction
endpackage

// File: hdl/vector_normalize.sv
// top level of the vector normalisation pipeline
//
//  port group        direction  payload
//  s_axis_*          in         four signed components per transfer
//  m_axis_*          out        unit vector, length, degenerate flag in tuser
//  i_cfg_we/_wdata   in         min_length register write
//
// one vector per cycle while the output is not stalled; the depth is set by the one-bit-per-stage
// square root and the 14-step per-lane divide
// every stage has its own valid bit and moves when the next stage is empty or moving,
// so bubbles close up and a stalled output holds without loss
// reset clears all valid bits and sets min_length to 1
module vector_normalize
    import vn_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
    parameter int LANES          = DEF_LANES,
    localparam int IN_W = ((NUM_LANES * COMPONENT_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,  // comp_x, comp_y, comp_z, comp_w
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // unit_x, unit_y, unit_z, unit_w, vec_length
    output logic                  m_axis_tuser,  // degenerate
    input  logic                  i_cfg_we,
    input  logic [MIN_LEN_W-1:0]  i_cfg_wdata
);
    localparam int CB    = COMPONENT_BITS;
    localparam int LW    = len_w(CB);
    localparam int CMP_W = (LW > MIN_LEN_W) ? LW : MIN_LEN_W;

    logic [MIN_LEN_W-1:0]               r_min_len;
    logic [NUM_LANES-1:0][CB-1:0]       comp;
    logic                               sq_valid, sq_ready, rt_valid, rt_ready;
    logic                               dv_valid, dv_ready;
    logic [2*LW-1:0]                    sq_sum;
    logic [NUM_LANES-1:0][CB-1:0]       sq_mag, rt_mag;
    logic [NUM_LANES-1:0]               sq_neg, rt_neg, dv_neg, dv_sat;
    logic [LW-1:0]                      rt_len, dv_len;
    logic [NUM_LANES-1:0][UNIT_SHIFT-1:0] dv_quot;

    logic                               r_ov;
    logic                               out_rdy;
    t_unit                              r_unit [NUM_LANES];
    t_unit                              n_unit [NUM_LANES];
    logic [LEN_OUT_W-1:0]               r_len;
    logic                               r_degen, n_degen;
    t_unit                              qv [NUM_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            comp[l] = s_axis_tdata[l*CB +: CB];
        end
    end

    vn_square #(.COMPONENT_BITS(CB), .LANES(LANES)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_comp  (comp),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_sum   (sq_sum),
        .o_mag   (sq_mag),
        .o_neg   (sq_neg)
    );

    vn_sqrt #(.COMPONENT_BITS(CB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .o_ready (sq_ready),
        .i_sum   (sq_sum),
        .i_mag   (sq_mag),
        .i_neg   (sq_neg),
        .o_valid (rt_valid),
        .i_ready (rt_ready),
        .o_len   (rt_len),
        .o_mag   (rt_mag),
        .o_neg   (rt_neg)
    );

    vn_div #(.COMPONENT_BITS(CB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rt_valid),
        .o_ready (rt_ready),
        .i_len   (rt_len),
        .i_mag   (rt_mag),
        .i_neg   (rt_neg),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_len   (dv_len),
        .o_quot  (dv_quot),
        .o_sat   (dv_sat),
        .o_neg   (dv_neg)
    );

    assign out_rdy  = !r_ov || m_axis_tready;
    assign dv_ready = out_rdy;

    always_comb begin
        // a zero length is degenerate even with min_length cleared
        n_degen = (dv_len == '0) || (CMP_W'(dv_len) < CMP_W'(r_min_len));
        for (int l = 0; l < NUM_LANES; l++) begin
            qv[l] = dv_sat[l] ? t_unit'(1 << UNIT_SHIFT) : t_unit'(dv_quot[l]);
            if (n_degen) begin
                n_unit[l] = '0;
            end else if (dv_neg[l]) begin
                n_unit[l] = ~qv[l] + t_unit'(1);
            end else begin
                n_unit[l] = qv[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_unit  <= n_unit;
            r_len   <= LEN_OUT_W'(dv_len);
            r_degen <= n_degen;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_degen;
    assign m_axis_tdata  = OUT_DATA_W'({r_len, r_unit[3], r_unit[2], r_unit[1], r_unit[0]});
endmodule

// File: hdl/vn_square.sv
// magnitude, square and sum-of-squares stages
module vn_square
    import vn_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
    parameter int LANES          = DEF_LANES
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]   i_comp,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [2*len_w(COMPONENT_BITS)-1:0]         o_sum,
    output logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]   o_mag,
    output logic [NUM_LANES-1:0]                       o_neg
);
    localparam int CB    = COMPONENT_BITS;
    localparam int LW    = len_w(CB);
    localparam int NW    = 2 * LW;
    localparam int SUM_W = 2 * CB + 2;
    localparam logic [SUM_W-1:0] SUM_MAX = (SUM_W > 64) ?
        ((SUM_W'(1) << 64) - SUM_W'(1)) : {SUM_W{1'b1}};

    logic                               r1_v, r2_v, r3_v;
    logic                               rdy1, rdy2, rdy3;
    logic [NUM_LANES-1:0][CB-1:0]       r1_mag, r2_mag, r3_mag, n1_mag;
    logic [NUM_LANES-1:0]               r1_neg, r2_neg, r3_neg, n1_neg;
    logic [NUM_LANES-1:0][2*CB-1:0]     r2_sq, n2_sq;
    logic [NW-1:0]                      r3_sum, n3_sum;
    logic [SUM_W-1:0]                   sum_full;

    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (l < LANES) begin
                n1_neg[l] = i_comp[l][CB-1];
                n1_mag[l] = i_comp[l][CB-1] ? (~i_comp[l] + CB'(1)) : i_comp[l];
            end else begin
                n1_neg[l] = 1'b0;
                n1_mag[l] = '0;
            end
            n2_sq[l] = (2*CB)'(r1_mag[l]) * (2*CB)'(r1_mag[l]);
        end
    end

    always_comb begin
        sum_full = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            sum_full = sum_full + SUM_W'(r2_sq[l]);
        end
        // only very wide components can pass the 64-bit ceiling
        n3_sum = (sum_full > SUM_MAX) ? {NW{1'b1}} : NW'(sum_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_mag <= n1_mag;
            r1_neg <= n1_neg;
        end
        if (rdy2) begin
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
            r2_sq  <= n2_sq;
        end
        if (rdy3) begin
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r3_sum <= n3_sum;
        end
    end

    assign o_valid = r3_v;
    assign o_sum   = r3_sum;
    assign o_mag   = r3_mag;
    assign o_neg   = r3_neg;
endmodule

// File: hdl/vn_sqrt.sv
// floor square root, one result bit per pipeline stage
module vn_sqrt
    import vn_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [2*len_w(COMPONENT_BITS)-1:0]         i_sum,
    input  logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]   i_mag,
    input  logic [NUM_LANES-1:0]                       i_neg,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [len_w(COMPONENT_BITS)-1:0]           o_len,
    output logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]   o_mag,
    output logic [NUM_LANES-1:0]                       o_neg
);
    localparam int CB = COMPONENT_BITS;
    localparam int LW = len_w(CB);
    localparam int NW = 2 * LW;
    localparam int RW = LW + 2;

    logic [LW-1:0]                          r_v;
    logic [LW:0]                            rdy;
    logic [LW-1:0][RW-1:0]                  r_rem, n_rem, src_rem;
    logic [LW-1:0][LW-1:0]                  r_root, n_root, src_root;
    logic [LW-1:0][NW-1:0]                  r_n, n_n, src_n;
    logic [LW-1:0][NUM_LANES-1:0][CB-1:0]   r_mag, src_mag;
    logic [LW-1:0][NUM_LANES-1:0]           r_neg, src_neg;
    logic [LW-1:0]                          src_v;
    logic [LW-1:0][RW+1:0]                  cur, trial;

    always_comb begin
        rdy[LW] = i_ready;
        for (int s = LW - 1; s >= 0; s--) begin
            rdy[s] = !r_v[s] || rdy[s+1];
        end
    end
    assign o_ready = rdy[0];

    always_comb begin
        for (int s = 0; s < LW; s++) begin
            if (s == 0) begin
                src_v[s]    = i_valid;
                src_rem[s]  = '0;
                src_root[s] = '0;
                src_n[s]    = i_sum;
                src_mag[s]  = i_mag;
                src_neg[s]  = i_neg;
            end else begin
                src_v[s]    = r_v[s-1];
                src_rem[s]  = r_rem[s-1];
                src_root[s] = r_root[s-1];
                src_n[s]    = r_n[s-1];
                src_mag[s]  = r_mag[s-1];
                src_neg[s]  = r_neg[s-1];
            end
            // bring down the next two bits and try root*4+1
            cur[s]   = {src_rem[s], src_n[s][NW-1:NW-2]};
            trial[s] = (RW+2)'({src_root[s], 2'b01});
            if (cur[s] >= trial[s]) begin
                n_rem[s]  = RW'(cur[s] - trial[s]);
                n_root[s] = {src_root[s][LW-2:0], 1'b1};
            end else begin
                n_rem[s]  = RW'(cur[s]);
                n_root[s] = {src_root[s][LW-2:0], 1'b0};
            end
            n_n[s] = {src_n[s][NW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < LW; s++) begin
                if (rdy[s]) r_v[s] <= src_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < LW; s++) begin
            if (rdy[s]) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_n[s]    <= n_n[s];
                r_mag[s]  <= src_mag[s];
                r_neg[s]  <= src_neg[s];
            end
        end
    end

    assign o_valid = r_v[LW-1];
    assign o_len   = r_root[LW-1];
    assign o_mag   = r_mag[LW-1];
    assign o_neg   = r_neg[LW-1];
endmodule

// File: hdl/vn_div.sv
// per-lane restoring divide of magnitude * 2^14 by the length
module vn_div
    import vn_pkg::*;
#(
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [len_w(COMPONENT_BITS)-1:0]           i_len,
    input  logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]   i_mag,
    input  logic [NUM_LANES-1:0]                       i_neg,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [len_w(COMPONENT_BITS)-1:0]           o_len,
    output logic [NUM_LANES-1:0][UNIT_SHIFT-1:0]       o_quot,
    output logic [NUM_LANES-1:0]                       o_sat,
    output logic [NUM_LANES-1:0]                       o_neg
);
    localparam int CB = COMPONENT_BITS;
    localparam int LW = len_w(CB);
    localparam int DW = LW + 1;
    localparam int NS = UNIT_SHIFT + 1;

    logic [NS-1:0]                                r_v, src_v;
    logic [NS:0]                                  rdy;
    logic [NS-1:0][LW-1:0]                        r_len, src_len;
    logic [NS-1:0][NUM_LANES-1:0][DW-1:0]         r_rem, n_rem;
    logic [NS-1:0][NUM_LANES-1:0][UNIT_SHIFT-1:0] r_q, n_q;
    logic [NS-1:0][NUM_LANES-1:0]                 r_sat, n_sat, r_neg, src_neg;
    logic [NS-1:0][NUM_LANES-1:0][DW-1:0]         shl;

    always_comb begin
        rdy[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            rdy[s] = !r_v[s] || rdy[s+1];
        end
    end
    assign o_ready = rdy[0];

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            src_v[s]   = (s == 0) ? i_valid : r_v[s-1];
            src_len[s] = (s == 0) ? i_len : r_len[s-1];
            src_neg[s] = (s == 0) ? i_neg : r_neg[s-1];
            for (int l = 0; l < NUM_LANES; l++) begin
                shl[s][l] = '0;
                if (s == 0) begin
                    // magnitude never exceeds the length unless the sum was clamped
                    n_sat[s][l] = LW'(i_mag[l]) >= i_len;
                    n_rem[s][l] = DW'(i_mag[l]);
                    n_q[s][l]   = '0;
                end else begin
                    n_sat[s][l] = r_sat[s-1][l];
                    shl[s][l]   = {r_rem[s-1][l][LW-1:0], 1'b0};
                    if (shl[s][l] >= DW'(r_len[s-1])) begin
                        n_rem[s][l] = shl[s][l] - DW'(r_len[s-1]);
                        n_q[s][l]   = {r_q[s-1][l][UNIT_SHIFT-2:0], 1'b1};
                    end else begin
                        n_rem[s][l] = shl[s][l];
                        n_q[s][l]   = {r_q[s-1][l][UNIT_SHIFT-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (rdy[s]) r_v[s] <= src_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            if (rdy[s]) begin
                r_len[s] <= src_len[s];
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_sat[s] <= n_sat[s];
                r_neg[s] <= src_neg[s];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_len   = r_len[NS-1];
    assign o_quot  = r_q[NS-1];
    assign o_sat   = r_sat[NS-1];
    assign o_neg   = r_neg[NS-1];
endmodule

// File: hdl/vn_checker.sv
// port-level checks for the vector normalisation block, bound to the top level
`include "vector_normalize_assert.svh"
module vn_checker
    import vn_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);
    logic signed [UNIT_W-1:0] ux, uy, uz, uw;
    logic                     units_ok;
    logic                     units_zero;
    logic                     len_zero;

    assign ux = m_axis_tdata[15:0];
    assign uy = m_axis_tdata[31:16];
    assign uz = m_axis_tdata[47:32];
    assign uw = m_axis_tdata[63:48];
    assign units_ok = (ux >= -16'sd16384) && (ux <= 16'sd16384) &&
                      (uy >= -16'sd16384) && (uy <= 16'sd16384) &&
                      (uz >= -16'sd16384) && (uz <= 16'sd16384) &&
                      (uw >= -16'sd16384) && (uw <= 16'sd16384);
    assign units_zero = (m_axis_tdata[63:0] == 64'd0);
    assign len_zero   = (m_axis_tdata[80:64] == 17'd0);

    `VN_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `VN_ASSERT_RUN(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `VN_ASSERT_RUN(a_degen_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> units_zero)
    `VN_ASSERT_RUN(a_unit_range, i_clk, i_rst_n, m_axis_tvalid |-> units_ok)
    `VN_ASSERT_RUN(a_len_nonzero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> !len_zero)
endmodule

bind vector_normalize vn_checker u_vn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_vector_normalize.sv
// testbench for vector_normalize: stream stimulus, self-checking against a behavioural predictor
module tb_vector_normalize;
    import vn_pkg::*;

    localparam int CB   = DEF_COMPONENT_BITS;
    localparam int IN_W = ((NUM_LANES * CB + 7) / 8) * 8;
    localparam int LATENCY = 3 + 17 + 15 + 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] ux, uy, uz, uw;
        logic [16:0] len;
        logic        degen;
    } unit_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [MIN_LEN_W-1:0]  i_cfg_wdata = '0;

    unit_result_t expected_units[$];
    logic [15:0]  min_len_shadow;
    int           mismatches = 0;
    longint       cycles = 0;
    bit           rx_stall_en = 1'b1;
    int           rx_wait = 0;

    vector_normalize dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic unit_result_t normalise(input logic signed [15:0] comp[4]);
        logic [63:0] mag[4];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic [15:0] u[4];
        bit          degen;
        unit_result_t r;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = (comp[i] < 0) ? 64'(-longint'(comp[i])) : 64'(comp[i]);
            sum += mag[i] * mag[i];
        end
        len   = floor_sqrt(sum);
        degen = (len < min_len_shadow) || (len == 0);
        for (int i = 0; i < 4; i++) begin
            q = 0;
            if (!degen) begin
                q = (mag[i] * 16384) / len;
                if (q > 16384) q = 16384;
                if (comp[i] < 0) q = -q;
            end
            u[i] = q[15:0];
        end
        r.ux = u[0]; r.uy = u[1]; r.uz = u[2]; r.uw = u[3];
        r.len = len[16:0];
        r.degen = degen;
        return r;
    endfunction

    // tvalid stays up after a transfer and drops only for a gap or a drain
    task automatic send_vector(input logic signed [15:0] x, y, z, w, input bit gaps = 1'b1);
        logic signed [15:0] comp[4];
        int gap;
        comp = '{x, y, z, w};
        gap = gaps ? $urandom_range(0, 6) : 0;
        if (gap != 0 && ($urandom_range(0, 3) == 0)) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {w, z, y, x};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_units.push_back(normalise(comp));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_units.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_min_length(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        min_len_shadow = v;
    endtask

    // receiver: random hold-off after each transfer, with stretches of none
    always @(negedge i_clk) begin
        if (!i_rst_n || !rx_stall_en) begin
            rx_wait = 0;
            m_axis_tready <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        unit_result_t got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rx_stall_en) rx_wait = $urandom_range(0, 6);
            got.ux = m_axis_tdata[15:0];
            got.uy = m_axis_tdata[31:16];
            got.uz = m_axis_tdata[47:32];
            got.uw = m_axis_tdata[63:48];
            got.len = m_axis_tdata[80:64];
            got.degen = m_axis_tuser;
            if (expected_units.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %p", got);
            end else begin
                exp_r = expected_units.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    task automatic test_directed_extremes();
        send_vector(0, 0, 0, 0);
        send_vector(16'sh7fff, 0, 0, 0);
        send_vector(-16'sd32768, 0, 0, 0);
        send_vector(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vector(1, 0, 0, 0);
        send_vector(0, -1, 0, 0);
        send_vector(3, 4, 0, 0);
        send_vector(1, 1, 1, 0);
        send_vector(-5, 12, 0, 0);
        send_vector(1, 1, 1, 1);
        send_vector(0, 0, 0, 16'sh5555);
        send_vector(0, 0, -16'sd21846, 0);
    endtask

    task automatic test_degenerate_threshold();
        wait_drained();
        write_min_length(16'd0);
        send_vector(0, 0, 0, 0);  // zero length stays degenerate
        send_vector(1, 0, 0, 0);
        wait_drained();
        write_min_length(16'd5);
        send_vector(3, 4, 0, 0);  // exactly at the threshold
        send_vector(2, 2, 0, 0);
        send_vector(4, 0, 0, 0);
        wait_drained();
        write_min_length(16'hffff);
        send_vector(16'sh7fff, 16'sh7fff, 0, 0);
        send_vector(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        wait_drained();
    endtask

    task automatic test_random_vectors(input int n, input logic [15:0] minlen);
        logic signed [15:0] c[4];
        int kind;
        wait_drained();
        write_min_length(minlen);
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 5);
            for (int i = 0; i < 4; i++) begin
                case (kind)
                    0: c[i] = $urandom_range(0, 8) - 4;
                    1: c[i] = $urandom_range(0, 512) - 256;
                    default: c[i] = $urandom;
                endcase
            end
            if (kind == 2) c[3] = 0;
            if (kind == 3) begin c[2] = 0; c[3] = 0; end
            send_vector(c[0], c[1], c[2], c[3], k % 100 < 80);
            // hold off until the pipeline is empty once per phase
            if (k == n / 2) wait_drained();
        end
    endtask

    initial begin
        min_len_shadow = MIN_LEN_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_degenerate_threshold();
        test_random_vectors(150, 16'd1);
        rx_stall_en = 1'b0;
        test_random_vectors(150, 16'd0);
        rx_stall_en = 1'b1;
        test_random_vectors(150, 16'd3);
        test_random_vectors(150, 16'd200);
        wait_drained();
        if (mismatches == 0 && expected_units.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
